/* hdl/prq_pkg.sv */
// shared types, constants and command/kind/status codes for the
// priority retry request queue; no dependencies
package prq_pkg;

  localparam int PRIORITY_LEVELS = 4;
  localparam int REQUEST_DEPTH   = 4;
  localparam int RESULT_DEPTH    = 8;

  localparam logic [7:0] RETRY_REFUSED = 8'd255;

  localparam logic [2:0] CMD_SUBMIT  = 3'd0;
  localparam logic [2:0] CMD_PROCESS = 3'd1;
  localparam logic [2:0] CMD_OUTCOME = 3'd2;
  localparam logic [2:0] CMD_POP     = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  localparam logic [2:0] KIND_ACK      = 3'd0;
  localparam logic [2:0] KIND_DISPATCH = 3'd1;
  localparam logic [2:0] KIND_DONE     = 3'd2;
  localparam logic [2:0] KIND_POPPED   = 3'd3;
  localparam logic [2:0] KIND_COUNTERS = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ARG_ERR   = 3'd1;
  localparam logic [2:0] ST_BUSY      = 3'd2;
  localparam logic [2:0] ST_NONE      = 3'd3;
  localparam logic [2:0] ST_UNEXPECT  = 3'd4;

  localparam logic [2:0] OST_OK    = 3'd0;
  localparam logic [2:0] OST_OTHER = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  priority_req;
    logic [15:0] caller_tag;
    logic [31:0] request_body;
    logic [7:0]  retry_limit;
    logic [2:0]  outcome_status;
    logic [31:0] response_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  status;
    logic [15:0] out_request_id;
    logic [31:0] out_request_body;
    logic [8:0]  attempt_number;
    logic [2:0]  final_status;
    logic [31:0] out_response_word;
    logic [31:0] success_total;
    logic [31:0] error_total;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    in_item_t   item;
    logic       prio_bad;
    logic       retry_bad;
  } work_t;

endpackage

/* hdl/prq_if.sv */
// valid/ready channel interface carrying one item type
// depends on prq_pkg for payload types
interface prq_in_if;
  logic              valid;
  logic              ready;
  prq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prq_out_if;
  logic               valid;
  logic               ready;
  prq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/prq_front.sv */
// front: accepts commands, checks arguments, two-entry queue to the back
// depends on prq_pkg
module prq_front #(
  parameter int PRIORITY_LEVELS = prq_pkg::PRIORITY_LEVELS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prq_pkg::in_item_t   in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output prq_pkg::work_t      q_data
);

  prq_pkg::work_t q_mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push, pop;
  prq_pkg::work_t w;

  always_comb begin
    w.item      = in_data;
    w.retry_bad = (in_data.retry_limit == prq_pkg::RETRY_REFUSED);
    w.prio_bad  = ({30'd0, in_data.priority_req} >= 32'(PRIORITY_LEVELS));
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = q_mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= w;
    end
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("front queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd2) |-> !in_ready)
    else $error("front accepts when full");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !push) |=> !q_valid)
    else $error("queue valid without entry");

endmodule

/* hdl/prq_back.sv */
// back: request fifos, result fifo, retry engine and output register
// depends on prq_pkg
module prq_back #(
  parameter int PRIORITY_LEVELS = prq_pkg::PRIORITY_LEVELS,
  parameter int REQUEST_DEPTH   = prq_pkg::REQUEST_DEPTH,
  parameter int RESULT_DEPTH    = prq_pkg::RESULT_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  prq_pkg::work_t      q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prq_pkg::out_item_t  out_data
);

  localparam int LW  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int QW  = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
  localparam int RW  = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
  localparam int QFW = $clog2(REQUEST_DEPTH + 1);
  localparam int RFW = $clog2(RESULT_DEPTH + 1);
  localparam int SW  = LW + QW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] body;
    logic [7:0]  retries;
  } req_t;

  typedef struct packed {
    logic [15:0] id;
    logic [8:0]  attempts;
    logic [2:0]  status;
    logic [31:0] response;
  } res_t;

  req_t req_mem [2**SW];
  res_t res_mem [RESULT_DEPTH];
  req_t req_rd_r;
  res_t res_rd_r;

  logic [QFW-1:0] fill_r [PRIORITY_LEVELS];
  logic [QW-1:0]  head_r [PRIORITY_LEVELS];
  logic [RFW-1:0] rfill_r;
  logic [RW-1:0]  rhead_r;
  logic           busy_r;
  req_t           fl_r;
  logic [8:0]     att_r;
  logic [31:0]    succ_r, err_r;
  logic [1:0]     state_r;
  logic           ovalid_r;
  prq_pkg::out_item_t odata_r;

  prq_pkg::in_item_t it;
  logic           any;
  logic [LW-1:0]  top;
  logic [2:0]     ost;
  logic           retry;
  logic           take;
  logic [LW-1:0]  lvl;
  logic [QW-1:0]  wslot;
  logic [RW-1:0]  rslot;
  logic           res_full;

  assign it = q_data.item;
  assign lvl = LW'(it.priority_req);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign res_full  = (rfill_r >= RFW'(RESULT_DEPTH));
  assign take = q_valid && (state_r == S_IDLE) && (!ovalid_r || out_ready);
  assign q_ready = take;

  always_comb begin
    any = 1'b0;
    top = '0;
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      if (fill_r[l] != '0) begin
        any = 1'b1;
        top = LW'(l);
      end
    end
  end

  always_comb begin
    logic [QW:0] s;
    logic [RW:0] r;
    s = {1'b0, head_r[lvl]} + {1'b0, fill_r[lvl][QW-1:0]};
    if (s >= (QW+1)'(REQUEST_DEPTH)) s = s - (QW+1)'(REQUEST_DEPTH);
    wslot = s[QW-1:0];
    r = {1'b0, rhead_r} + {1'b0, rfill_r[RW-1:0]};
    if (r >= (RW+1)'(RESULT_DEPTH)) r = r - (RW+1)'(RESULT_DEPTH);
    rslot = r[RW-1:0];
  end

  assign ost = (it.outcome_status > prq_pkg::OST_OTHER) ? prq_pkg::OST_OTHER
                                                        : it.outcome_status;
  assign retry = (ost != prq_pkg::OST_OK) && (ost != prq_pkg::OST_OTHER) &&
                 (att_r <= {1'b0, fl_r.retries});

  function automatic logic [QW-1:0] inc_q(logic [QW-1:0] v);
    inc_q = (32'(v) == REQUEST_DEPTH - 1) ? '0 : v + QW'(1);
  endfunction

  function automatic logic [RW-1:0] inc_r(logic [RW-1:0] v);
    inc_r = (32'(v) == RESULT_DEPTH - 1) ? '0 : v + RW'(1);
  endfunction

  always_ff @(posedge clk) begin
    prq_pkg::out_item_t o;
    o = '0;
    if (take) begin
      case (it.cmd)
        prq_pkg::CMD_SUBMIT: begin
          if (!q_data.retry_bad && !q_data.prio_bad &&
              fill_r[lvl] < QFW'(REQUEST_DEPTH)) begin
            req_mem[SW'({lvl, wslot})] <= '{it.caller_tag, it.request_body, it.retry_limit};
          end
        end
        prq_pkg::CMD_PROCESS: begin
          req_rd_r <= req_mem[SW'({top, head_r[top]})];
        end
        prq_pkg::CMD_OUTCOME: begin
          if (busy_r && !retry && !res_full) begin
            res_mem[rslot] <= '{fl_r.id, att_r, ost, it.response_word};
          end
        end
        prq_pkg::CMD_POP: begin
          res_rd_r <= res_mem[rhead_r];
        end
        default: ;
      endcase
    end
    if (!rst_n) begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        fill_r[l] <= '0;
        head_r[l] <= '0;
      end
      rfill_r  <= '0;
      rhead_r  <= '0;
      busy_r   <= 1'b0;
      att_r    <= '0;
      succ_r   <= '0;
      err_r    <= '0;
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      fl_r     <= '0;
    end else begin
      case (state_r)
        S_READ: begin
          fl_r   <= req_rd_r;
          busy_r <= 1'b1;
          att_r  <= 9'd1;
          o.kind = prq_pkg::KIND_DISPATCH;
          o.out_request_id   = req_rd_r.id;
          o.out_request_body = req_rd_r.body;
          o.attempt_number   = 9'd1;
          odata_r  <= o;
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        S_POP: begin
          o.kind = prq_pkg::KIND_POPPED;
          o.out_request_id    = res_rd_r.id;
          o.attempt_number    = res_rd_r.attempts;
          o.final_status      = res_rd_r.status;
          o.out_response_word = res_rd_r.response;
          odata_r  <= o;
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: begin
          if (!take) begin
            if (out_ready) ovalid_r <= 1'b0;
          end else begin
            case (it.cmd)
              prq_pkg::CMD_SUBMIT: begin
                o.kind = prq_pkg::KIND_ACK;
                o.out_request_id = it.caller_tag;
                if (q_data.retry_bad || q_data.prio_bad) begin
                  o.status = prq_pkg::ST_ARG_ERR;
                end else if (fill_r[lvl] >= QFW'(REQUEST_DEPTH)) begin
                  o.status = prq_pkg::ST_BUSY;
                end else begin
                  fill_r[lvl] <= fill_r[lvl] + QFW'(1);
                end
                odata_r <= o; ovalid_r <= 1'b1;
              end
              prq_pkg::CMD_PROCESS: begin
                if (busy_r || res_full) begin
                  o.status = prq_pkg::ST_BUSY;
                  odata_r <= o; ovalid_r <= 1'b1;
                end else if (!any) begin
                  o.status = prq_pkg::ST_NONE;
                  odata_r <= o; ovalid_r <= 1'b1;
                end else begin
                  head_r[top] <= inc_q(head_r[top]);
                  fill_r[top] <= fill_r[top] - QFW'(1);
                  ovalid_r <= 1'b0;
                  state_r <= S_READ;
                end
              end
              prq_pkg::CMD_OUTCOME: begin
                if (!busy_r) begin
                  o.status = prq_pkg::ST_UNEXPECT;
                end else if (retry) begin
                  att_r <= att_r + 9'd1;
                  o.kind = prq_pkg::KIND_DISPATCH;
                  o.out_request_id   = fl_r.id;
                  o.out_request_body = fl_r.body;
                  o.attempt_number   = att_r + 9'd1;
                end else begin
                  if (ost == prq_pkg::OST_OK) succ_r <= succ_r + 32'd1;
                  else err_r <= err_r + 32'd1;
                  if (!res_full) rfill_r <= rfill_r + RFW'(1);
                  busy_r <= 1'b0;
                  o.kind = prq_pkg::KIND_DONE;
                  o.out_request_id    = fl_r.id;
                  o.attempt_number    = att_r;
                  o.final_status      = ost;
                  o.out_response_word = it.response_word;
                end
                odata_r <= o; ovalid_r <= 1'b1;
              end
              prq_pkg::CMD_POP: begin
                if (rfill_r == '0) begin
                  o.status = prq_pkg::ST_NONE;
                  odata_r <= o; ovalid_r <= 1'b1;
                end else begin
                  rhead_r <= inc_r(rhead_r);
                  rfill_r <= rfill_r - RFW'(1);
                  ovalid_r <= 1'b0;
                  state_r <= S_POP;
                end
              end
              prq_pkg::CMD_READ: begin
                o.kind = prq_pkg::KIND_COUNTERS;
                o.success_total = succ_r;
                o.error_total   = err_r;
                odata_r <= o; ovalid_r <= 1'b1;
              end
              default: begin
                o.status = prq_pkg::ST_ARG_ERR;
                odata_r <= o; ovalid_r <= 1'b1;
              end
            endcase
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) rfill_r <= RFW'(RESULT_DEPTH))
    else $error("result fifo overfilled");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_READ) |=> busy_r)
    else $error("dispatch without busy");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !q_ready)
    else $error("command taken mid-access");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |=> ovalid_r)
    else $error("access finished without result");

endmodule

/* hdl/priority_retry_request_queue.sv */
// Strict-priority bus request queue with retry. Each command gives exactly one
// result. Process (when it dispatches) and pop pass through an extra access
// state, since the request or result memory read is registered before the
// result is formed. A two-entry command queue in front lets new commands
// arrive while a result waits to be taken. No clearing pass.
// depends on prq_pkg, prq_if, prq_front, prq_back
module priority_retry_request_queue #(
  parameter int PRIORITY_LEVELS = prq_pkg::PRIORITY_LEVELS,
  parameter int REQUEST_DEPTH   = prq_pkg::REQUEST_DEPTH,
  parameter int RESULT_DEPTH    = prq_pkg::RESULT_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  prq_in_if.sink    in_ch,
  prq_out_if.source out_ch
);

  logic           q_valid, q_ready;
  prq_pkg::work_t q_data;

  prq_front #(.PRIORITY_LEVELS(PRIORITY_LEVELS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_ready, .q_data
  );

  prq_back #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .REQUEST_DEPTH(REQUEST_DEPTH),
    .RESULT_DEPTH(RESULT_DEPTH)
  ) u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

endmodule

/* verif/prq_checker.sv */
// request scheduler checker: mirrors queue state, predicts one result per command
// transfer and compares it field by field; depends on prq_pkg and prq_if
module prq_checker (
  input  logic      clk,
  input  logic      rst_n,
  prq_in_if.sink    cmd_mon,
  prq_out_if.sink   res_mon,
  output int        fail_count,
  output int        pending_count
);
  import prq_pkg::*;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] body;
    logic [7:0]  retries;
  } req_entry_t;

  typedef struct packed {
    logic [15:0] id;
    logic [8:0]  attempts;
    logic [2:0]  status;
    logic [31:0] response;
  } res_entry_t;

  req_entry_t  req_mem [PRIORITY_LEVELS][REQUEST_DEPTH];
  int unsigned req_cnt [PRIORITY_LEVELS];
  int unsigned req_rd  [PRIORITY_LEVELS];
  res_entry_t  res_mem [RESULT_DEPTH];
  int unsigned res_cnt, res_rd;
  logic        busy;
  req_entry_t  active;
  logic [8:0]  tries;
  logic [31:0] ok_total, err_total;
  out_item_t   expected_results[$];

  function automatic out_item_t schedule(input in_item_t c);
    out_item_t   r;
    int          lvl;
    int unsigned slot;
    logic [2:0]  ost;
    r = '0;
    r.kind = KIND_ACK;
    r.status = ST_OK;
    case (c.cmd)
      CMD_SUBMIT: begin
        r.out_request_id = c.caller_tag;
        if (c.retry_limit == RETRY_REFUSED || int'(c.priority_req) >= PRIORITY_LEVELS) begin
          r.status = ST_ARG_ERR;
        end else if (req_cnt[c.priority_req] >= REQUEST_DEPTH) begin
          r.status = ST_BUSY;
        end else begin
          slot = (req_rd[c.priority_req] + req_cnt[c.priority_req]) % REQUEST_DEPTH;
          req_mem[c.priority_req][slot] = '{c.caller_tag, c.request_body, c.retry_limit};
          req_cnt[c.priority_req]++;
        end
      end
      CMD_PROCESS: begin
        if (busy || res_cnt >= RESULT_DEPTH) begin
          r.status = ST_BUSY;
        end else begin
          for (lvl = PRIORITY_LEVELS - 1; lvl >= 0; lvl--)
            if (req_cnt[lvl] != 0) break;
          if (lvl < 0) begin
            r.status = ST_NONE;
          end else begin
            active = req_mem[lvl][req_rd[lvl]];
            req_rd[lvl] = (req_rd[lvl] + 1) % REQUEST_DEPTH;
            req_cnt[lvl]--;
            busy = 1'b1;
            tries = 9'd1;
            r.kind = KIND_DISPATCH;
            r.out_request_id = active.id;
            r.out_request_body = active.body;
            r.attempt_number = tries;
          end
        end
      end
      CMD_OUTCOME: begin
        if (!busy) begin
          r.status = ST_UNEXPECT;
        end else begin
          ost = (c.outcome_status > OST_OTHER) ? OST_OTHER : c.outcome_status;
          if (ost != OST_OK && ost != OST_OTHER && tries <= {1'b0, active.retries}) begin
            tries = tries + 9'd1;
            r.kind = KIND_DISPATCH;
            r.out_request_id = active.id;
            r.out_request_body = active.body;
            r.attempt_number = tries;
          end else begin
            if (ost == OST_OK) ok_total++;
            else err_total++;
            if (res_cnt < RESULT_DEPTH) begin
              res_mem[(res_rd + res_cnt) % RESULT_DEPTH] =
                '{active.id, tries, ost, c.response_word};
              res_cnt++;
            end
            busy = 1'b0;
            r.kind = KIND_DONE;
            r.out_request_id = active.id;
            r.attempt_number = tries;
            r.final_status = ost;
            r.out_response_word = c.response_word;
          end
        end
      end
      CMD_POP: begin
        if (res_cnt == 0) begin
          r.status = ST_NONE;
        end else begin
          r.kind = KIND_POPPED;
          r.out_request_id = res_mem[res_rd].id;
          r.attempt_number = res_mem[res_rd].attempts;
          r.final_status = res_mem[res_rd].status;
          r.out_response_word = res_mem[res_rd].response;
          res_rd = (res_rd + 1) % RESULT_DEPTH;
          res_cnt--;
        end
      end
      CMD_READ: begin
        r.kind = KIND_COUNTERS;
        r.success_total = ok_total;
        r.error_total = err_total;
      end
      default: r.status = ST_ARG_ERR;
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e, a;
    if (!rst_n) begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        req_cnt[l] = 0;
        req_rd[l] = 0;
      end
      res_cnt = 0;
      res_rd = 0;
      busy = 1'b0;
      active = '0;
      tries = '0;
      ok_total = '0;
      err_total = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        a = res_mon.data;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result transfer: expected none actual %h", $time, a);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          compare_field("kind", e.kind, a.kind);
          compare_field("status", e.status, a.status);
          compare_field("out_request_id", e.out_request_id, a.out_request_id);
          compare_field("request_body", e.out_request_body, a.out_request_body);
          compare_field("attempt_number", e.attempt_number, a.attempt_number);
          compare_field("final_status", e.final_status, a.final_status);
          compare_field("response_word", e.out_response_word, a.out_response_word);
          compare_field("success_total", e.success_total, a.success_total);
          compare_field("error_total", e.error_total, a.error_total);
        end
      end
      if (cmd_mon.valid && cmd_mon.ready)
        expected_results.push_back(schedule(cmd_mon.data));
    end
    pending_count = expected_results.size();
  end
endmodule

/* verif/priority_retry_request_queue_tb.sv */
// stimulus and verdict for the priority retry request queue: directed commands,
// then idle/stall phases of random scheduling traffic; depends on prq_pkg, prq_if, prq_checker
module priority_retry_request_queue_tb;
  import prq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   phase_num = 0;
  int   hold_cycles;

  prq_in_if  cmd_ch ();
  prq_out_if res_ch ();

  priority_retry_request_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch.sink),
    .out_ch (res_ch.source)
  );

  prq_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_mon       (cmd_ch.sink),
    .res_mon       (res_ch.sink),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("priority_retry_request_queue_tb: errors");
      $finish;
    end
  end

  // receiver: random stall, plus a long counted hold-off in the pressure phase
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      hold_cycles <= 200;
    end else if (phase_num == 4 && hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic in_item_t make_cmd(input logic [2:0] c, input logic [1:0] p,
                                        input logic [7:0] rl, input logic [2:0] o);
    in_item_t x;
    x.cmd = c;
    x.priority_req = p;
    x.caller_tag = 16'($urandom);
    x.request_body = $urandom;
    x.retry_limit = rl;
    x.outcome_status = o;
    x.response_word = $urandom;
    return x;
  endfunction

  task automatic send_cmd(input in_item_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= x;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic send_random;
    int          r;
    logic [7:0]  rl;
    logic [2:0]  o;
    r = $urandom_range(99);
    rl = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    o = ($urandom_range(7) == 0) ? 3'($urandom) : 3'($urandom_range(4));
    if (r < 30)      send_cmd(make_cmd(CMD_SUBMIT, 2'($urandom), rl, o));
    else if (r < 50) send_cmd(make_cmd(CMD_PROCESS, 2'($urandom), rl, o));
    else if (r < 78) send_cmd(make_cmd(CMD_OUTCOME, 2'($urandom), rl, o));
    else if (r < 92) send_cmd(make_cmd(CMD_POP, 2'($urandom), rl, o));
    else if (r < 97) send_cmd(make_cmd(CMD_READ, 2'($urandom), rl, o));
    else             send_cmd(make_cmd(3'($urandom_range(7, 5)), 2'($urandom), rl, o));
  endtask

  initial begin
    in_item_t x;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-queue cases, extremes, refusals, retries, unknown codes
    send_cmd(make_cmd(CMD_PROCESS, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(CMD_OUTCOME, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(CMD_POP, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(CMD_SUBMIT, 2'd3, RETRY_REFUSED, 3'd0));
    x = make_cmd(CMD_SUBMIT, 2'd0, 8'd254, 3'd0);
    x.caller_tag = '1;
    x.request_body = '1;
    send_cmd(x);
    x = make_cmd(CMD_SUBMIT, 2'd3, 8'd1, 3'd0);
    x.caller_tag = '0;
    x.request_body = '0;
    send_cmd(x);
    for (int i = 0; i < 5; i++) send_cmd(make_cmd(CMD_SUBMIT, 2'd2, 8'd0, 3'd0));
    send_cmd(make_cmd(CMD_PROCESS, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(CMD_PROCESS, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(CMD_OUTCOME, 2'd0, 8'd0, 3'd1));
    send_cmd(make_cmd(CMD_OUTCOME, 2'd0, 8'd0, 3'd2));
    send_cmd(make_cmd(CMD_PROCESS, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(CMD_OUTCOME, 2'd0, 8'd0, 3'd7));
    send_cmd(make_cmd(CMD_PROCESS, 2'd0, 8'd0, 3'd0));
    x = make_cmd(CMD_OUTCOME, 2'd0, 8'd0, 3'd3);
    x.response_word = '1;
    send_cmd(x);
    send_cmd(make_cmd(CMD_OUTCOME, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(CMD_POP, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(CMD_READ, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(3'd7, 2'd0, 8'd0, 3'd0));
    send_cmd(make_cmd(3'd5, 2'd0, 8'd0, 3'd0));

    // drain the remaining level-two requests
    for (int i = 0; i < 2; i++) begin
      send_cmd(make_cmd(CMD_PROCESS, 2'd0, 8'd0, 3'd0));
      send_cmd(make_cmd(CMD_OUTCOME, 2'd0, 8'd0, 3'd0));
    end

    // long retry chain up to the largest accepted limit
    send_cmd(make_cmd(CMD_PROCESS, 2'd0, 8'd0, 3'd0));
    for (int i = 0; i < 256; i++) send_cmd(make_cmd(CMD_OUTCOME, 2'd0, 8'd0, 3'd1));

    // random phases with different idle and stall rates
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        3: begin send_idle_pct = 35; stall_pct = 35; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      phase_num = ph;
      for (int i = 0; i < 300; i++) send_random();
    end

    cmd_ch.valid <= 1'b0;
    stall_pct = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("priority_retry_request_queue_tb: clean");
    end else begin
      $display("priority_retry_request_queue_tb: errors");
    end
    $finish;
  end
endmodule
